FILE: hw/rtl/wsb_pkg.sv
`timescale 1ns / 1ps

package wsb_pkg;

  // window and block geometry
  localparam int unsigned WINDOW      = 8;
  localparam int unsigned SLOT_W      = $clog2(WINDOW);
  localparam int unsigned BLOCK_BYTES = 2048;
  localparam int unsigned STALL_MS    = 1000;
  localparam int unsigned RATE_FLOOR  = 1000;
  localparam int unsigned RATE_DIV    = 1000;
  localparam int unsigned MAX_OUT     = 8;

  // field widths
  localparam int unsigned OP_W     = 3;
  localparam int unsigned STATUS_W = 3;
  localparam int unsigned FSIZE_W  = 31;
  localparam int unsigned COUNT_W  = 12;
  localparam int unsigned BLK_W    = 16;
  localparam int unsigned RATE_W   = 20;
  localparam int unsigned SNAP_W   = 10;
  localparam int unsigned MS_W     = 32;
  localparam int unsigned PROD_W   = RATE_W + SNAP_W;
  localparam int unsigned CNT_W    = $clog2(MAX_OUT + 1);

  // threshold grows by one block budget per descriptor sent
  localparam int unsigned THR_STEP = BLOCK_BYTES * RATE_DIV;

  typedef logic [SLOT_W-1:0]  slot_t;
  typedef logic [FSIZE_W-1:0] fsize_t;
  typedef logic [COUNT_W-1:0] count_t;
  typedef logic [BLK_W-1:0]   blk_t;
  typedef logic [RATE_W-1:0]  rate_t;
  typedef logic [SNAP_W-1:0]  snap_t;
  typedef logic [MS_W-1:0]    ms_t;
  typedef logic [PROD_W-1:0]  prod_t;
  typedef logic [CNT_W-1:0]   cnt_t;

  typedef enum logic [OP_W-1:0] {
    OP_START   = 3'd0,
    OP_FILL    = 3'd1,
    OP_SERVICE = 3'd2,
    OP_ACK     = 3'd3,
    OP_RETX    = 3'd4,
    OP_STOP    = 3'd5
  } op_e;

  typedef enum logic [STATUS_W-1:0] {
    STATUS_OK        = 3'd0,
    STATUS_IGNORED   = 3'd1,
    STATUS_BROKEN    = 3'd2,
    STATUS_DONE      = 3'd3,
    STATUS_NOT_FOUND = 3'd4
  } status_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DECODE,
    ST_ACK_CHK,
    ST_MUL,
    ST_EVAL,
    ST_EMIT,
    ST_RESP
  } state_e;

  // sequencer commands to the rate unit
  typedef struct packed {
    logic load;
    logic mul;
    logic step;
  } rate_ctl_t;

  // one result word
  typedef struct packed {
    logic    kind;
    status_e status;
    blk_t    blk;
    slot_t   slot;
    count_t  count;
    logic    inc;
    fsize_t  total;
    logic    last;
  } result_t;

endpackage

FILE: hw/rtl/wsb_ram.sv
`timescale 1ns / 1ps

module wsb_ram #(
  parameter int unsigned Width = 12,
  parameter int unsigned Depth = 8
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: hw/rtl/wsb_rate.sv
`timescale 1ns / 1ps

module wsb_rate (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  wsb_pkg::rate_t     cfg_max_rate_i,
  input  wsb_pkg::rate_ctl_t ctl_i,
  input  wsb_pkg::rate_t     rate_i,
  input  wsb_pkg::snap_t     snap_i,
  output logic               ok_o
);

  wsb_pkg::rate_t max_rate_q;
  wsb_pkg::rate_t cap;
  wsb_pkg::rate_t rate_eff;
  wsb_pkg::rate_t rate_q;
  wsb_pkg::snap_t snap_q;
  wsb_pkg::prod_t prod_q;
  wsb_pkg::prod_t thr_q;

  // server rate cap register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_rate_q <= '0;
    end else if (cfg_we_i) begin
      max_rate_q <= cfg_max_rate_i;
    end
  end

  // cap the client rate, small nonzero caps act as the floor
  always_comb begin
    cap = (max_rate_q < wsb_pkg::rate_t'(wsb_pkg::RATE_FLOOR))
        ? wsb_pkg::rate_t'(wsb_pkg::RATE_FLOOR) : max_rate_q;
    rate_eff = rate_i;
    if ((max_rate_q != '0) && (cap < rate_i)) begin
      rate_eff = cap;
    end
  end

  // bytes per frame, then a running threshold of block budgets
  always_ff @(posedge clk_i) begin
    if (ctl_i.load) begin
      rate_q <= rate_eff;
      snap_q <= snap_i;
    end
    if (ctl_i.mul) begin
      prod_q <= wsb_pkg::prod_t'(rate_q) * wsb_pkg::prod_t'(snap_q);
      thr_q  <= '0;
    end else if (ctl_i.step) begin
      thr_q <= thr_q + wsb_pkg::prod_t'(wsb_pkg::THR_STEP);
    end
  end

  // shared compare: another descriptor fits in the budget
  assign ok_o = (prod_q >= thr_q);

endmodule

FILE: hw/rtl/wsb_ctrl.sv
`timescale 1ns / 1ps

module wsb_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic [2:0]          operation_i,
  input  wsb_pkg::fsize_t     file_size_i,
  input  wsb_pkg::count_t     fill_bytes_i,
  input  logic                read_error_i,
  input  wsb_pkg::blk_t       block_number_i,
  input  wsb_pkg::rate_t      client_rate_i,
  input  wsb_pkg::snap_t      snapshot_msec_i,
  input  wsb_pkg::ms_t        now_ms_i,
  input  logic                cfg_we_i,
  input  wsb_pkg::rate_t      cfg_max_rate_i,
  input  logic                can_push_i,
  output logic                push_o,
  output wsb_pkg::result_t    res_o
);

  wsb_pkg::state_e  state_q, state_d;
  logic             active_q, active_d;
  wsb_pkg::blk_t    tx_q, tx_d;
  wsb_pkg::blk_t    ack_q, ack_d;
  wsb_pkg::blk_t    buf_q, buf_d;
  wsb_pkg::fsize_t  loaded_q, loaded_d;
  wsb_pkg::fsize_t  fsize_q, fsize_d;
  logic             endq_q, endq_d;
  wsb_pkg::ms_t     last_act_q, last_act_d;
  wsb_pkg::cnt_t    n_q, n_d;
  logic             pend_q, pend_d;
  wsb_pkg::blk_t    pend_blk_q, pend_blk_d;
  wsb_pkg::count_t  pend_cnt_q, pend_cnt_d;
  wsb_pkg::status_e status_q, status_d;

  // latched input word
  wsb_pkg::op_e    op_q;
  wsb_pkg::fsize_t in_fsize_q;
  wsb_pkg::count_t fill_q;
  logic            rerr_q;
  wsb_pkg::blk_t   blk_in_q;
  wsb_pkg::rate_t  crate_q;
  wsb_pkg::snap_t  snap_q;
  wsb_pkg::ms_t    now_q;

  logic               accept;
  logic               room;
  wsb_pkg::count_t    fill_sat;
  wsb_pkg::fsize_t    gap;
  wsb_pkg::ms_t       elapsed;
  logic               stalled;
  logic               stop;
  wsb_pkg::blk_t      tx_sel;
  logic               rate_ok;
  wsb_pkg::rate_ctl_t rate_ctl;

  logic                  ram_we;
  wsb_pkg::slot_t        ram_waddr;
  wsb_pkg::count_t       ram_wdata;
  logic                  ram_re;
  wsb_pkg::slot_t        ram_raddr;
  wsb_pkg::count_t       ram_rdata;

  assign in_stall_o = (state_q != wsb_pkg::ST_IDLE);
  assign accept     = in_valid_i && !in_stall_o;

  // per-slot byte counts
  wsb_ram #(
    .Width(wsb_pkg::COUNT_W),
    .Depth(wsb_pkg::WINDOW)
  ) u_slot_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .re_i   (ram_re),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  // rate budget unit
  wsb_rate u_rate (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_max_rate_i(cfg_max_rate_i),
    .ctl_i         (rate_ctl),
    .rate_i        (crate_q),
    .snap_i        (snap_q),
    .ok_o          (rate_ok)
  );

  // input word capture
  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q       <= wsb_pkg::op_e'(operation_i);
      in_fsize_q <= file_size_i;
      fill_q     <= fill_bytes_i;
      rerr_q     <= read_error_i;
      blk_in_q   <= block_number_i;
      crate_q    <= client_rate_i;
      snap_q     <= snapshot_msec_i;
      now_q      <= now_ms_i;
    end
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= wsb_pkg::ST_IDLE;
      active_q   <= 1'b0;
      tx_q       <= '0;
      ack_q      <= '0;
      buf_q      <= '0;
      loaded_q   <= '0;
      fsize_q    <= '0;
      endq_q     <= 1'b0;
      last_act_q <= '0;
      n_q        <= '0;
      pend_q     <= 1'b0;
      status_q   <= wsb_pkg::STATUS_OK;
    end else begin
      state_q    <= state_d;
      active_q   <= active_d;
      tx_q       <= tx_d;
      ack_q      <= ack_d;
      buf_q      <= buf_d;
      loaded_q   <= loaded_d;
      fsize_q    <= fsize_d;
      endq_q     <= endq_d;
      last_act_q <= last_act_d;
      n_q        <= n_d;
      pend_q     <= pend_d;
      status_q   <= status_d;
    end
  end

  // pending descriptor payload
  always_ff @(posedge clk_i) begin
    pend_blk_q <= pend_blk_d;
    pend_cnt_q <= pend_cnt_d;
  end

  // shared conditions
  always_comb begin
    room     = (wsb_pkg::blk_t'(buf_q - ack_q) < wsb_pkg::blk_t'(wsb_pkg::WINDOW));
    fill_sat = (fill_q > wsb_pkg::BLOCK_BYTES)
             ? wsb_pkg::count_t'(wsb_pkg::BLOCK_BYTES) : fill_q;
    gap      = fsize_q - loaded_q;
    elapsed  = now_q - last_act_q;
    stalled  = !elapsed[wsb_pkg::MS_W-1] && (elapsed > wsb_pkg::ms_t'(wsb_pkg::STALL_MS));
    stop     = (n_q == wsb_pkg::cnt_t'(wsb_pkg::MAX_OUT)) || !rate_ok ||
               (ack_q == buf_q) || ((tx_q == buf_q) && !stalled);
    tx_sel   = (tx_q == buf_q) ? ack_q : tx_q;
  end

  // sequencer
  always_comb begin
    state_d    = state_q;
    active_d   = active_q;
    tx_d       = tx_q;
    ack_d      = ack_q;
    buf_d      = buf_q;
    loaded_d   = loaded_q;
    fsize_d    = fsize_q;
    endq_d     = endq_q;
    last_act_d = last_act_q;
    n_d        = n_q;
    pend_d     = pend_q;
    pend_blk_d = pend_blk_q;
    pend_cnt_d = pend_cnt_q;
    status_d   = status_q;
    ram_we     = 1'b0;
    ram_waddr  = buf_q[wsb_pkg::SLOT_W-1:0];
    ram_wdata  = '0;
    ram_re     = 1'b0;
    ram_raddr  = ack_q[wsb_pkg::SLOT_W-1:0];
    rate_ctl   = '0;
    push_o     = 1'b0;
    res_o      = '0;

    case (state_q)
      wsb_pkg::ST_IDLE: begin
        if (accept) begin
          state_d = wsb_pkg::ST_DECODE;
        end
      end

      wsb_pkg::ST_DECODE: begin
        state_d  = wsb_pkg::ST_RESP;
        status_d = wsb_pkg::STATUS_IGNORED;
        case (op_q)
          wsb_pkg::OP_START: begin
            active_d = 1'b0;
            if (in_fsize_q == '0) begin
              status_d = wsb_pkg::STATUS_NOT_FOUND;
            end else begin
              active_d = 1'b1;
              fsize_d  = in_fsize_q;
              tx_d     = '0;
              ack_d    = '0;
              buf_d    = '0;
              loaded_d = '0;
              endq_d   = 1'b0;
              status_d = wsb_pkg::STATUS_OK;
            end
          end
          wsb_pkg::OP_FILL: begin
            if (active_q && room && (loaded_q != fsize_q)) begin
              status_d = wsb_pkg::STATUS_OK;
              if (rerr_q) begin
                loaded_d = fsize_q;
              end else begin
                ram_we    = 1'b1;
                ram_wdata = fill_sat;
                buf_d     = buf_q + 1'b1;
                loaded_d  = (gap < wsb_pkg::fsize_t'(fill_sat))
                          ? fsize_q : loaded_q + wsb_pkg::fsize_t'(fill_sat);
              end
            end
          end
          wsb_pkg::OP_SERVICE: begin
            if (active_q) begin
              // queue the zero-length end block once the file is loaded
              if ((loaded_q == fsize_q) && !endq_q && room) begin
                ram_we    = 1'b1;
                ram_wdata = '0;
                buf_d     = buf_q + 1'b1;
                endq_d    = 1'b1;
              end
              rate_ctl.load = 1'b1;
              state_d       = wsb_pkg::ST_MUL;
            end
          end
          wsb_pkg::OP_ACK: begin
            if (active_q) begin
              if ((blk_in_q != ack_q) || (ack_q == buf_q)) begin
                active_d = 1'b0;
                status_d = wsb_pkg::STATUS_BROKEN;
              end else begin
                ram_re    = 1'b1;
                ram_raddr = ack_q[wsb_pkg::SLOT_W-1:0];
                state_d   = wsb_pkg::ST_ACK_CHK;
              end
            end
          end
          wsb_pkg::OP_RETX: begin
            if (active_q && (blk_in_q == ack_q)) begin
              tx_d     = ack_q;
              status_d = wsb_pkg::STATUS_OK;
            end
          end
          wsb_pkg::OP_STOP: begin
            active_d = 1'b0;
            status_d = wsb_pkg::STATUS_OK;
          end
          default: begin
            status_d = wsb_pkg::STATUS_IGNORED;
          end
        endcase
      end

      wsb_pkg::ST_ACK_CHK: begin
        // zero byte count marks the end block
        if (ram_rdata == '0) begin
          active_d = 1'b0;
          status_d = wsb_pkg::STATUS_DONE;
        end else begin
          last_act_d = now_q;
          ack_d      = ack_q + 1'b1;
          status_d   = wsb_pkg::STATUS_OK;
        end
        state_d = wsb_pkg::ST_RESP;
      end

      wsb_pkg::ST_MUL: begin
        rate_ctl.mul = 1'b1;
        n_d          = '0;
        pend_d       = 1'b0;
        state_d      = wsb_pkg::ST_EVAL;
      end

      wsb_pkg::ST_EVAL: begin
        // the held descriptor goes out once the next step is decided
        if (!pend_q || can_push_i) begin
          if (pend_q) begin
            push_o       = 1'b1;
            res_o.kind   = 1'b1;
            res_o.status = wsb_pkg::STATUS_OK;
            res_o.blk    = pend_blk_q;
            res_o.slot   = pend_blk_q[wsb_pkg::SLOT_W-1:0];
            res_o.count  = pend_cnt_q;
            res_o.inc    = (pend_blk_q == '0);
            res_o.total  = (pend_blk_q == '0) ? fsize_q : '0;
            res_o.last   = stop;
            pend_d       = 1'b0;
          end
          if (stop) begin
            if (pend_q) begin
              state_d = wsb_pkg::ST_IDLE;
            end else begin
              status_d = wsb_pkg::STATUS_OK;
              state_d  = wsb_pkg::ST_RESP;
            end
          end else begin
            tx_d      = tx_sel;
            ram_re    = 1'b1;
            ram_raddr = tx_sel[wsb_pkg::SLOT_W-1:0];
            state_d   = wsb_pkg::ST_EMIT;
          end
        end
      end

      wsb_pkg::ST_EMIT: begin
        pend_d        = 1'b1;
        pend_blk_d    = tx_q;
        pend_cnt_d    = ram_rdata;
        tx_d          = tx_q + 1'b1;
        last_act_d    = now_q;
        n_d           = n_q + 1'b1;
        rate_ctl.step = 1'b1;
        state_d       = wsb_pkg::ST_EVAL;
      end

      wsb_pkg::ST_RESP: begin
        if (can_push_i) begin
          push_o       = 1'b1;
          res_o.status = status_q;
          res_o.last   = 1'b1;
          state_d      = wsb_pkg::ST_IDLE;
        end
      end

      default: begin
        state_d = wsb_pkg::ST_IDLE;
      end
    endcase
  end

  // checks
  a_push_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_o |-> can_push_i)
    else $error("result pushed into a full output register");

  a_status_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_o && !res_o.kind) |-> res_o.last)
    else $error("status word not marked last");

  a_window: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wsb_pkg::blk_t'(buf_q - ack_q) <= wsb_pkg::blk_t'(wsb_pkg::WINDOW))
    else $error("window occupancy above window size");

  a_emit_pend: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == wsb_pkg::ST_EMIT) |=> (pend_q && (state_q == wsb_pkg::ST_EVAL)))
    else $error("emitted descriptor not held");

  a_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    n_q <= wsb_pkg::cnt_t'(wsb_pkg::MAX_OUT))
    else $error("descriptor count above limit");

endmodule

FILE: hw/rtl/wsb_out.sv
`timescale 1ns / 1ps

module wsb_out (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  wsb_pkg::result_t res_i,
  output logic             can_push_o,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output wsb_pkg::result_t res_o
);

  logic             valid_q;
  wsb_pkg::result_t res_q;

  // room when empty or when the held word leaves this cycle
  assign can_push_o = !valid_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (push_i) begin
      valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      res_q <= res_i;
    end
  end

  assign out_valid_o = valid_q;
  assign res_o       = res_q;

endmodule

FILE: hw/rtl/windowed_block_sender.sv
`timescale 1ns / 1ps

// Go-back-N block sender with an 8-slot window of 2048-byte blocks. Each input
// word is taken only while the block is idle and yields one status word, or,
// for a service word that sends, one descriptor word per block (at most 8),
// the final word of each input marked by last. An acknowledge of the expected
// block reads the slot count from the slot RAM before it answers; one that
// breaks the download answers without that read. A service word of an open
// download first loads and multiplies the rate; each descriptor then needs one
// registered read of the slot RAM and one pass of the shared rate compare,
// which tests the frame byte budget against a running threshold of block
// sizes. An output stall holds each result word until the output register has
// room. The slot RAM needs no clearing pass after reset. A rewind after a stall
// happens when more than 1000 ms pass without a descriptor or acknowledge.
// max_rate is written through the configuration port, which is always ready,
// and should be written while idle.
module windowed_block_sender (
  input  logic        clk_i,
  input  logic        rst_ni,
  // input words
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [2:0]  operation_i,
  input  logic [30:0] file_size_i,
  input  logic [11:0] fill_bytes_i,
  input  logic        read_error_i,
  input  logic [15:0] block_number_i,
  input  logic [19:0] client_rate_i,
  input  logic [9:0]  snapshot_msec_i,
  input  logic [31:0] now_ms_i,
  // result words
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic        kind_o,
  output logic [2:0]  status_o,
  output logic [15:0] sent_block_o,
  output logic [2:0]  slot_o,
  output logic [11:0] byte_count_o,
  output logic        size_included_o,
  output logic [30:0] total_size_o,
  output logic        last_o,
  // configuration
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [19:0] cfg_max_rate_i
);

  logic             push;
  logic             can_push;
  wsb_pkg::result_t res_in;
  wsb_pkg::result_t res_out;

  assign cfg_ready_o = 1'b1;

  // sequencer, window state, slot RAM and rate unit
  wsb_ctrl u_ctrl (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .operation_i    (operation_i),
    .file_size_i    (file_size_i),
    .fill_bytes_i   (fill_bytes_i),
    .read_error_i   (read_error_i),
    .block_number_i (block_number_i),
    .client_rate_i  (client_rate_i),
    .snapshot_msec_i(snapshot_msec_i),
    .now_ms_i       (now_ms_i),
    .cfg_we_i       (cfg_valid_i && cfg_ready_o),
    .cfg_max_rate_i (cfg_max_rate_i),
    .can_push_i     (can_push),
    .push_o         (push),
    .res_o          (res_in)
  );

  // output register
  wsb_out u_out (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .res_i      (res_in),
    .can_push_o (can_push),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .res_o      (res_out)
  );

  // split the result word onto its ports
  assign kind_o          = res_out.kind;
  assign status_o        = res_out.status;
  assign sent_block_o    = res_out.blk;
  assign slot_o          = res_out.slot;
  assign byte_count_o    = res_out.count;
  assign size_included_o = res_out.inc;
  assign total_size_o    = res_out.total;
  assign last_o          = res_out.last;

endmodule

FILE: tb/sv/windowed_block_sender_test.sv
`timescale 1ns / 1ps

module windowed_block_sender_test;
  import wsb_pkg::*;

  // opcodes outside the defined set
  localparam logic [OP_W-1:0] OP_RSVD6 = 3'd6;
  localparam logic [OP_W-1:0] OP_RSVD7 = 3'd7;
  // directed rows: expectation typed in or taken from the predictor
  localparam bit TYPED   = 1'b1;
  localparam bit PREDICT = 1'b0;
  localparam int unsigned HOLD_CYCLES = 300;

  typedef struct packed {
    logic [OP_W-1:0] op;
    fsize_t          file_size;
    count_t          fill;
    logic            rerr;
    blk_t            blk;
    rate_t           crate;
    snap_t           snap;
    ms_t             now;
  } word_t;

  typedef struct packed {
    word_t   w;
    bit      typed;
    status_e st;
  } drow_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic [2:0]  operation_i = '0;
  logic [30:0] file_size_i = '0;
  logic [11:0] fill_bytes_i = '0;
  logic        read_error_i = 1'b0;
  logic [15:0] block_number_i = '0;
  logic [19:0] client_rate_i = '0;
  logic [9:0]  snapshot_msec_i = '0;
  logic [31:0] now_ms_i = '0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic        kind_o;
  logic [2:0]  status_o;
  logic [15:0] sent_block_o;
  logic [2:0]  slot_o;
  logic [11:0] byte_count_o;
  logic        size_included_o;
  logic [30:0] total_size_o;
  logic        last_o;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [19:0] cfg_max_rate_i = '0;

  windowed_block_sender u_top (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .operation_i    (operation_i),
    .file_size_i    (file_size_i),
    .fill_bytes_i   (fill_bytes_i),
    .read_error_i   (read_error_i),
    .block_number_i (block_number_i),
    .client_rate_i  (client_rate_i),
    .snapshot_msec_i(snapshot_msec_i),
    .now_ms_i       (now_ms_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .kind_o         (kind_o),
    .status_o       (status_o),
    .sent_block_o   (sent_block_o),
    .slot_o         (slot_o),
    .byte_count_o   (byte_count_o),
    .size_included_o(size_included_o),
    .total_size_o   (total_size_o),
    .last_o         (last_o),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_max_rate_i (cfg_max_rate_i)
  );

  // 10 ns clock
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // sender state as the block should hold it
  logic   win_active;
  blk_t   tx_ptr, acked_ptr, filled_ptr;
  fsize_t loaded_bytes, file_bytes;
  logic   eof_queued;
  ms_t    last_progress_ms;
  count_t slot_bytes [WINDOW];
  rate_t  rate_cap;

  result_t item_results [$];
  result_t pending_results [$];
  drow_t   script [$];
  ms_t     sim_ms;
  int      idle_pct, stall_pct;
  int      checked_count;
  int      fail_count;

  function automatic bit window_has_space();
    blk_t used;
    used = filled_ptr - acked_ptr;
    return used < WINDOW;
  endfunction

  // next sender state and the result words for one accepted input word
  function automatic void compute_block_results(input word_t w);
    result_t     r;
    logic [63:0] rate, budget, cap;
    ms_t         gap;
    slot_t       s;
    count_t      fill;
    bit          halted;
    item_results.delete();
    r = '0;
    r.last = 1'b1;
    r.status = STATUS_OK;
    case (w.op)
      OP_START: begin
        win_active = 1'b0;
        if (w.file_size == '0) begin
          r.status = STATUS_NOT_FOUND;
        end else begin
          win_active = 1'b1;
          file_bytes = w.file_size;
          tx_ptr = '0;
          acked_ptr = '0;
          filled_ptr = '0;
          loaded_bytes = '0;
          eof_queued = 1'b0;
        end
      end
      OP_FILL: begin
        if (!win_active || !window_has_space() || loaded_bytes == file_bytes) begin
          r.status = STATUS_IGNORED;
        end else if (w.rerr) begin
          loaded_bytes = file_bytes;
        end else begin
          fill = (w.fill > BLOCK_BYTES) ? count_t'(BLOCK_BYTES) : w.fill;
          slot_bytes[slot_t'(filled_ptr % WINDOW)] = fill;
          if (file_bytes - loaded_bytes < fsize_t'(fill)) loaded_bytes = file_bytes;
          else loaded_bytes = loaded_bytes + fsize_t'(fill);
          filled_ptr = filled_ptr + 1'b1;
        end
      end
      OP_SERVICE: begin
        if (!win_active) begin
          r.status = STATUS_IGNORED;
        end else begin
          // queue the zero-length end block once everything is loaded
          if (loaded_bytes == file_bytes && !eof_queued && window_has_space()) begin
            slot_bytes[slot_t'(filled_ptr % WINDOW)] = '0;
            filled_ptr = filled_ptr + 1'b1;
            eof_queued = 1'b1;
          end
          rate = 64'(w.crate);
          if (rate_cap != '0) begin
            cap = (rate_cap < RATE_FLOOR) ? 64'(RATE_FLOOR) : 64'(rate_cap);
            if (cap < rate) rate = cap;
          end
          if (rate == '0) budget = 64'd1;
          else budget = (rate * 64'(w.snap) / RATE_DIV + BLOCK_BYTES) / BLOCK_BYTES;
          if (budget > MAX_OUT) budget = 64'(MAX_OUT);
          halted = 1'b0;
          while (budget > 0 && !halted) begin
            budget = budget - 1;
            if (acked_ptr == filled_ptr) begin
              halted = 1'b1;
            end else begin
              // rewind only after a stall longer than the limit
              if (tx_ptr == filled_ptr) begin
                gap = w.now - last_progress_ms;
                if (gap[31] || gap <= STALL_MS) halted = 1'b1;
                else tx_ptr = acked_ptr;
              end
              if (!halted) begin
                s = slot_t'(tx_ptr % WINDOW);
                r = '0;
                r.kind = 1'b1;
                r.status = STATUS_OK;
                r.blk = tx_ptr;
                r.slot = s;
                r.count = slot_bytes[s];
                r.inc = (tx_ptr == '0);
                r.total = r.inc ? file_bytes : '0;
                item_results.push_back(r);
                tx_ptr = tx_ptr + 1'b1;
                last_progress_ms = w.now;
              end
            end
          end
          if (item_results.size() != 0) begin
            item_results[item_results.size() - 1].last = 1'b1;
          end else begin
            r = '0;
            r.last = 1'b1;
            r.status = STATUS_OK;
          end
        end
      end
      OP_ACK: begin
        if (!win_active) begin
          r.status = STATUS_IGNORED;
        end else if (w.blk != acked_ptr || acked_ptr == filled_ptr) begin
          win_active = 1'b0;
          r.status = STATUS_BROKEN;
        end else if (slot_bytes[slot_t'(acked_ptr % WINDOW)] == '0) begin
          win_active = 1'b0;
          r.status = STATUS_DONE;
        end else begin
          last_progress_ms = w.now;
          acked_ptr = acked_ptr + 1'b1;
        end
      end
      OP_RETX: begin
        if (!win_active || w.blk != acked_ptr) r.status = STATUS_IGNORED;
        else tx_ptr = acked_ptr;
      end
      OP_STOP: begin
        win_active = 1'b0;
      end
      default: begin
        r.status = STATUS_IGNORED;
      end
    endcase
    if (item_results.size() == 0) item_results.push_back(r);
  endfunction

  function automatic drow_t mk_row(input logic [OP_W-1:0] op, input fsize_t size,
                                   input count_t fill, input logic rerr, input blk_t blk,
                                   input rate_t crate, input snap_t snap, input ms_t now,
                                   input bit typed, input status_e st);
    drow_t d;
    d.w.op = op;
    d.w.file_size = size;
    d.w.fill = fill;
    d.w.rerr = rerr;
    d.w.blk = blk;
    d.w.crate = crate;
    d.w.snap = snap;
    d.w.now = now;
    d.typed = typed;
    d.st = st;
    return d;
  endfunction

  // mostly well-formed download traffic with random content, some noise
  function automatic word_t next_random_word();
    word_t w;
    int    pick, r;
    w.op = OP_STOP;
    w.file_size = fsize_t'($urandom);
    w.fill = count_t'($urandom);
    w.rerr = 1'($urandom_range(1));
    w.blk = blk_t'($urandom);
    w.crate = rate_t'($urandom);
    w.snap = snap_t'($urandom_range(1023));
    r = $urandom_range(99);
    if (r < 80) sim_ms = sim_ms + ms_t'($urandom_range(200));
    else if (r < 94) sim_ms = sim_ms + ms_t'($urandom_range(3000, 1001));
    else if (r < 97) sim_ms = sim_ms + ms_t'(STALL_MS);
    else sim_ms = sim_ms - ms_t'($urandom_range(3000));
    w.now = sim_ms;
    pick = $urandom_range(99);
    r = $urandom_range(99);
    if (pick < 5) begin
      w.op = 3'($urandom_range(7));
    end else if (!win_active) begin
      w.op = OP_START;
      if (r < 3) w.file_size = '0;
      else if (r < 90) w.file_size = fsize_t'($urandom_range(16000, 1));
    end else if (pick < 40 && window_has_space() && loaded_bytes != file_bytes) begin
      w.op = OP_FILL;
      w.rerr = (r < 3);
      if (r < 60) w.fill = count_t'(BLOCK_BYTES);
      else if (r < 85) w.fill = count_t'($urandom_range(BLOCK_BYTES));
    end else if (pick < 70) begin
      w.op = OP_SERVICE;
      if (r < 15) w.crate = '0;
      else if (r < 55) w.crate = rate_t'($urandom_range(20000));
      if ($urandom_range(99) < 90) w.snap = snap_t'($urandom_range(1000));
    end else if (pick < 90 && (acked_ptr != filled_ptr || r < 5)) begin
      w.op = OP_ACK;
      if ($urandom_range(99) < 94) w.blk = acked_ptr;
    end else if (pick < 98) begin
      w.op = OP_RETX;
      if (r < 85) w.blk = acked_ptr;
    end
    return w;
  endfunction

  // offer one word, wait for acceptance, then record what it should produce
  task automatic send_word(input word_t w, input bit typed, input status_e st);
    result_t t;
    while ($urandom_range(99) < idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    operation_i <= w.op;
    file_size_i <= w.file_size;
    fill_bytes_i <= w.fill;
    read_error_i <= w.rerr;
    block_number_i <= w.blk;
    client_rate_i <= w.crate;
    snapshot_msec_i <= w.snap;
    now_ms_i <= w.now;
    @(negedge clk_i);
    while (in_stall_o) @(negedge clk_i);
    @(posedge clk_i);
    compute_block_results(w);
    if (typed) begin
      t = '0;
      t.status = st;
      t.last = 1'b1;
      pending_results.push_back(t);
    end else begin
      foreach (item_results[i]) pending_results.push_back(item_results[i]);
    end
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_rate_cap(input rate_t v);
    cfg_valid_i <= 1'b1;
    cfg_max_rate_i <= v;
    @(negedge clk_i);
    while (!cfg_ready_o) @(negedge clk_i);
    @(posedge clk_i);
    cfg_valid_i <= 1'b0;
    rate_cap = v;
  endtask

  // stimulus
  initial begin
    rate_t cap;
    win_active = 1'b0;
    tx_ptr = '0;
    acked_ptr = '0;
    filled_ptr = '0;
    loaded_bytes = '0;
    file_bytes = '0;
    eof_queued = 1'b0;
    last_progress_ms = '0;
    rate_cap = '0;
    foreach (slot_bytes[i]) slot_bytes[i] = '0;
    idle_pct = 20;
    stall_pct = 20;
    checked_count = 0;
    fail_count = 0;
    sim_ms = '0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: ignored while closed, open/fill/send/rewind, end of file, errors
    script.push_back(mk_row(OP_FILL, '0, '0, 1'b0, '0, '0, '0, '0, TYPED, STATUS_IGNORED));
    script.push_back(mk_row(OP_SERVICE, '0, '0, 1'b0, '0, '0, '0, '0, TYPED, STATUS_IGNORED));
    script.push_back(mk_row(OP_ACK, '0, '0, 1'b0, '0, '0, '0, '0, TYPED, STATUS_IGNORED));
    script.push_back(mk_row(OP_RETX, '0, '0, 1'b0, '0, '0, '0, '0, TYPED, STATUS_IGNORED));
    script.push_back(mk_row(OP_RSVD6, '0, '0, 1'b0, '0, '0, '0, '0, TYPED, STATUS_IGNORED));
    script.push_back(mk_row(OP_RSVD7, '1, '1, 1'b1, '1, '1, '1, '1, TYPED, STATUS_IGNORED));
    script.push_back(mk_row(OP_START, '0, '0, 1'b0, '0, '0, '0, '0, TYPED, STATUS_NOT_FOUND));
    script.push_back(mk_row(OP_START, '1, '0, 1'b0, '0, '0, '0, '0, TYPED, STATUS_OK));
    // oversized fill saturates, then a read error finishes the file
    script.push_back(mk_row(OP_FILL, '0, '1, 1'b0, '0, '0, '0, '0, TYPED, STATUS_OK));
    script.push_back(mk_row(OP_FILL, '0, '0, 1'b1, '0, '0, '0, '0, TYPED, STATUS_OK));
    script.push_back(mk_row(OP_FILL, '0, '0, 1'b0, '0, '0, '0, '0, TYPED, STATUS_IGNORED));
    script.push_back(mk_row(OP_SERVICE, '0, '0, 1'b0, '0, '1, '1, '0, PREDICT, STATUS_OK));
    script.push_back(mk_row(OP_SERVICE, '0, '0, 1'b0, '0, '0, '0, 32'd500, PREDICT, STATUS_OK));
    // no progress for over a second: rewind
    script.push_back(mk_row(OP_SERVICE, '0, '0, 1'b0, '0, '0, '0, 32'd2000, PREDICT, STATUS_OK));
    script.push_back(mk_row(OP_RETX, '0, '0, 1'b0, '1, '0, '0, '0, TYPED, STATUS_IGNORED));
    script.push_back(mk_row(OP_RETX, '0, '0, 1'b0, '0, '0, '0, '0, TYPED, STATUS_OK));
    script.push_back(mk_row(OP_ACK, '0, '0, 1'b0, '0, '0, '0, '0, TYPED, STATUS_OK));
    script.push_back(mk_row(OP_ACK, '0, '0, 1'b0, 16'd1, '0, '0, '0, TYPED, STATUS_DONE));
    // empty data block, one-byte file, single block at zero rate
    script.push_back(mk_row(OP_START, 31'd1, '0, 1'b0, '0, '0, '0, '0, TYPED, STATUS_OK));
    script.push_back(mk_row(OP_FILL, '0, '0, 1'b0, '0, '0, '0, '0, TYPED, STATUS_OK));
    script.push_back(mk_row(OP_FILL, '0, 12'd1, 1'b0, '0, '0, '0, '0, TYPED, STATUS_OK));
    script.push_back(mk_row(OP_SERVICE, '0, '0, 1'b0, '0, '0, '0, '1, PREDICT, STATUS_OK));
    script.push_back(mk_row(OP_ACK, '0, '0, 1'b0, '1, '0, '0, '0, TYPED, STATUS_BROKEN));
    // acknowledge before anything is buffered
    script.push_back(mk_row(OP_START, 31'd5000, '0, 1'b0, '0, '0, '0, '0, TYPED, STATUS_OK));
    script.push_back(mk_row(OP_ACK, '0, '0, 1'b0, '0, '0, '0, '0, TYPED, STATUS_BROKEN));
    script.push_back(mk_row(OP_STOP, '0, '0, 1'b0, '0, '0, '0, '0, TYPED, STATUS_OK));
    foreach (script[i]) send_word(script[i].w, script[i].typed, script[i].st);

    // random phases, each with its own rate cap
    for (int p = 0; p < 5; p++) begin
      drain();
      case (p)
        0: cap = '1;
        1: cap = 20'd500;
        2: cap = rate_t'(RATE_FLOOR);
        3: cap = '0;
        default: cap = rate_t'($urandom);
      endcase
      write_rate_cap(cap);
      idle_pct = (p == 1) ? 0 : 20;
      stall_pct = (p == 1) ? 0 : 20;
      sim_ms = (p == 2) ? 32'hFFFF_F000 : ms_t'($urandom);
      for (int i = 0; i < 90; i++) send_word(next_random_word(), PREDICT, STATUS_OK);
    end

    drain();
    repeat (40) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  // receiver stalls, with one long hold-off to back the block up
  initial begin
    int  hold_left;
    bit  held;
    hold_left = 0;
    held = 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_left > 0) begin
        hold_left = hold_left - 1;
        out_stall_i <= 1'b1;
      end else if (!held && checked_count >= 120) begin
        held = 1'b1;
        hold_left = HOLD_CYCLES;
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= ($urandom_range(99) < stall_pct);
      end
    end
  end

  function automatic void check_field(input string name, input logic [31:0] want,
                                      input logic [31:0] got);
    if (want !== got) begin
      $error("%s mismatch: expected %0d, got %0d", name, want, got);
      fail_count++;
    end
  endfunction

  // compare each accepted result word with the oldest expectation
  always @(negedge clk_i) begin : result_check
    result_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_results.size() == 0) begin
        $error("result word with nothing pending: kind %0d block %0d status %0d",
               kind_o, sent_block_o, status_o);
        fail_count++;
      end else begin
        want = pending_results.pop_front();
        check_field("kind", 32'(want.kind), 32'(kind_o));
        check_field("status", 32'(want.status), 32'(status_o));
        check_field("sent_block", 32'(want.blk), 32'(sent_block_o));
        check_field("slot", 32'(want.slot), 32'(slot_o));
        check_field("byte_count", 32'(want.count), 32'(byte_count_o));
        check_field("size_included", 32'(want.inc), 32'(size_included_o));
        check_field("total_size", 32'(want.total), 32'(total_size_o));
        check_field("last", 32'(want.last), 32'(last_o));
      end
      checked_count++;
    end
  end

  // run limit
  initial begin
    #5_000_000;
    $display("Regression FAIL");
    $finish;
  end

endmodule

FILE: windowed_block_sender.f
hw/rtl/wsb_pkg.sv
hw/rtl/wsb_ram.sv
hw/rtl/wsb_rate.sv
hw/rtl/wsb_ctrl.sv
hw/rtl/wsb_out.sv
hw/rtl/windowed_block_sender.sv
tb/sv/windowed_block_sender_test.sv
